### rtl/core/pfrgba_pkg.sv
// pfrgba_pkg: shared types, constants and divider step functions for the
// pixel format to rgba8 converter; no dependencies

package pfrgba_pkg;

    // sizes and defaults
    localparam int MAX_PIXEL_BYTES_DEF = 4;
    localparam int RAW_W               = 32;
    localparam int APB_DATA_W          = 32;
    localparam int APB_ADDR_W          = 5;
    localparam int CH_W                = 8;
    localparam int NUM_LANES           = 4;
    localparam int DIV_STAGES          = 4;
    localparam int DIV_BITS            = 2;

    // lanes of the divider array
    localparam int LANE_RED   = 0;
    localparam int LANE_GREEN = 1;
    localparam int LANE_BLUE  = 2;
    localparam int LANE_ALPHA = 3;

    // register map, word index
    typedef enum logic [2:0] {
        REG_BYTES_PER_PIXEL = 3'd0,
        REG_SWAP_BYTES      = 3'd1,
        REG_COLOUR_DEPTH    = 3'd2,
        REG_CHANNEL_SHIFTS  = 3'd3,
        REG_RED_MAX         = 3'd4,
        REG_GREEN_MAX       = 3'd5,
        REG_BLUE_MAX        = 3'd6
    } cfg_index_t;

    // register reset values
    localparam logic [2:0]  RST_BYTES_PER_PIXEL = 3'd4;
    localparam logic        RST_SWAP_BYTES      = 1'b0;
    localparam logic [5:0]  RST_COLOUR_DEPTH    = 6'd24;
    localparam logic [14:0] RST_CHANNEL_SHIFTS  = 15'd16;
    localparam logic [7:0]  RST_CHANNEL_MAX     = 8'd255;

    // one lane of the restoring divider: partial remainder, dividend bits
    // still to shift in, quotient bits so far
    typedef struct packed {
        logic [CH_W-1:0] rem;
        logic [CH_W-1:0] low;
        logic [CH_W-1:0] quo;
    } div_lane_t;

    // dividend is value*255; its top byte is below the divisor because
    // value never exceeds the divisor
    function automatic div_lane_t div_init(logic [CH_W-1:0] value);
        logic [2*CH_W-1:0] prod;
        div_lane_t         lane;
        prod     = {value, {CH_W{1'b0}}} - {{CH_W{1'b0}}, value};
        lane.rem = prod[2*CH_W-1:CH_W];
        lane.low = prod[CH_W-1:0];
        lane.quo = '0;
        return lane;
    endfunction

    // DIV_BITS quotient bits of the restoring division
    function automatic div_lane_t div_step(div_lane_t lane_in, logic [CH_W-1:0] divisor);
        div_lane_t     lane;
        logic [CH_W:0] trial;
        logic          qbit;
        lane = lane_in;
        for (int b = 0; b < DIV_BITS; b++) begin
            trial = {lane.rem, lane.low[CH_W-1]};
            qbit  = 1'b0;
            if (trial >= {1'b0, divisor}) begin
                trial = trial - {1'b0, divisor};
                qbit  = 1'b1;
            end
            lane.rem = trial[CH_W-1:0];
            lane.low = {lane.low[CH_W-2:0], 1'b0};
            lane.quo = {lane.quo[CH_W-2:0], qbit};
        end
        return lane;
    endfunction

endpackage

### rtl/core/pixel_format_to_rgba8_unit.sv
// pixel_format_to_rgba8_unit: raw true-colour pixel to 8-bit rgba, uses pfrgba_pkg
// one item per cycle sustained while the output is not stalled (m_ready high)
// stages: byte mask and swap, channel extract and *255, then four divider stages
// of two quotient bits each, the last feeding the output register
// a stalled stage holds while upstream bubbles still fill; aresetn (sync, low)
// clears all valid bits and loads the register defaults

module pixel_format_to_rgba8_unit
    import pfrgba_pkg::*;
#(
    parameter int MAX_PIXEL_BYTES = MAX_PIXEL_BYTES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // input items
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [RAW_W-1:0]      s_raw_pixel,
    // result items
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CH_W-1:0]       m_red_out,
    output logic [CH_W-1:0]       m_green_out,
    output logic [CH_W-1:0]       m_blue_out,
    output logic [CH_W-1:0]       m_alpha_out
);

    localparam int PIX_W   = MAX_PIXEL_BYTES * 8;
    localparam int EXT_W   = (PIX_W > RAW_W) ? PIX_W : RAW_W;
    localparam int NB_W    = $clog2(MAX_PIXEL_BYTES + 1);
    localparam int NBITS_W = NB_W + 3;

    // configuration registers
    logic [2:0]      bpp_reg;
    logic            swap_reg;
    logic [5:0]      depth_reg;
    logic [14:0]     shifts_reg;
    logic [CH_W-1:0] red_max_reg;
    logic [CH_W-1:0] green_max_reg;
    logic [CH_W-1:0] blue_max_reg;

    cfg_index_t      cfg_idx;
    logic            cfg_wr;

    // pipeline
    logic                 pvalid_reg;
    logic [PIX_W-1:0]     pix_reg;
    logic [PIX_W-1:0]     pix_next;
    logic                 dvalid_reg [DIV_STAGES];
    div_lane_t            dlane_reg  [DIV_STAGES][NUM_LANES];
    div_lane_t            dinit_next [NUM_LANES];
    div_lane_t            dlast_next [NUM_LANES];
    logic                 en_d       [DIV_STAGES];
    logic                 en_p;
    logic                 en_out;
    logic                 m_valid_reg;
    logic [CH_W-1:0]      m_red_out_reg;
    logic [CH_W-1:0]      m_green_out_reg;
    logic [CH_W-1:0]      m_blue_out_reg;
    logic [CH_W-1:0]      m_alpha_out_reg;

    // derived from configuration
    logic [NB_W-1:0]      nbytes;
    logic [NBITS_W-1:0]   nbits;
    logic [6:0]           alpha_span;
    logic [3:0]           alpha_w;
    logic [CH_W-1:0]      alpha_max;
    logic [CH_W-1:0]      divisor    [NUM_LANES];

    // apb write decode
    assign cfg_idx = cfg_index_t'(paddr[APB_ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_reg       <= RST_BYTES_PER_PIXEL;
            swap_reg      <= RST_SWAP_BYTES;
            depth_reg     <= RST_COLOUR_DEPTH;
            shifts_reg    <= RST_CHANNEL_SHIFTS;
            red_max_reg   <= RST_CHANNEL_MAX;
            green_max_reg <= RST_CHANNEL_MAX;
            blue_max_reg  <= RST_CHANNEL_MAX;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_BYTES_PER_PIXEL: bpp_reg       <= pwdata[2:0];
                REG_SWAP_BYTES:      swap_reg      <= pwdata[0];
                REG_COLOUR_DEPTH:    depth_reg     <= pwdata[5:0];
                REG_CHANNEL_SHIFTS:  shifts_reg    <= pwdata[14:0];
                REG_RED_MAX:         red_max_reg   <= pwdata[CH_W-1:0];
                REG_GREEN_MAX:       green_max_reg <= pwdata[CH_W-1:0];
                REG_BLUE_MAX:        blue_max_reg  <= pwdata[CH_W-1:0];
                default: ;
            endcase
        end
    end

    // apb read mux
    always_comb begin
        unique case (cfg_idx)
            REG_BYTES_PER_PIXEL: prdata = APB_DATA_W'(bpp_reg);
            REG_SWAP_BYTES:      prdata = APB_DATA_W'(swap_reg);
            REG_COLOUR_DEPTH:    prdata = APB_DATA_W'(depth_reg);
            REG_CHANNEL_SHIFTS:  prdata = APB_DATA_W'(shifts_reg);
            REG_RED_MAX:         prdata = APB_DATA_W'(red_max_reg);
            REG_GREEN_MAX:       prdata = APB_DATA_W'(green_max_reg);
            REG_BLUE_MAX:        prdata = APB_DATA_W'(blue_max_reg);
            default:             prdata = '0;
        endcase
    end

    // pixel size, alpha field width and divisors
    always_comb begin
        if (int'(bpp_reg) > MAX_PIXEL_BYTES) begin
            nbytes = NB_W'(MAX_PIXEL_BYTES);
        end else begin
            nbytes = NB_W'(bpp_reg);
        end
        nbits = {nbytes, 3'b000};
        if (7'(depth_reg) < 7'(nbits)) begin
            alpha_span = 7'(nbits) - 7'(depth_reg);
        end else begin
            alpha_span = '0;
        end
        if (alpha_span > 7'd8) begin
            alpha_w = 4'd8;
        end else begin
            alpha_w = alpha_span[3:0];
        end
        alpha_max             = CH_W'((9'd1 << alpha_w) - 9'd1);
        divisor[LANE_RED]     = red_max_reg;
        divisor[LANE_GREEN]   = green_max_reg;
        divisor[LANE_BLUE]    = blue_max_reg;
        divisor[LANE_ALPHA]   = alpha_max;
    end

    // stall chain: a stage moves when empty or when the next one moves
    always_comb begin
        en_out               = !m_valid_reg || m_ready;
        en_d[DIV_STAGES-1]   = !dvalid_reg[DIV_STAGES-1] || en_out;
        for (int k = DIV_STAGES - 2; k >= 0; k--) begin
            en_d[k] = !dvalid_reg[k] || en_d[k+1];
        end
        en_p = !pvalid_reg || en_d[0];
    end

    assign s_ready = en_p;

    // stage 1: keep the pixel's bytes, reverse them when asked
    always_comb begin
        logic [EXT_W-1:0]   raw_ext;
        logic [PIX_W-1:0]   kept;
        logic [PIX_W-1:0]   rev;
        logic [NBITS_W-1:0] rshift;
        raw_ext = EXT_W'(s_raw_pixel);
        for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
            if (i < int'(nbytes)) begin
                kept[8*i +: 8] = raw_ext[8*i +: 8];
            end else begin
                kept[8*i +: 8] = 8'h00;
            end
        end
        for (int j = 0; j < MAX_PIXEL_BYTES; j++) begin
            rev[8*j +: 8] = kept[8*(MAX_PIXEL_BYTES-1-j) +: 8];
        end
        // unused bytes land at the bottom of the reversed word
        rshift = NBITS_W'(PIX_W) - nbits;
        if (swap_reg) begin
            pix_next = rev >> rshift;
        end else begin
            pix_next = kept;
        end
    end

    // stage 2: extract channels and alpha, start the divisions
    always_comb begin
        logic [CH_W-1:0] val [NUM_LANES];
        val[LANE_RED]   = CH_W'(pix_reg >> shifts_reg[4:0])   & red_max_reg;
        val[LANE_GREEN] = CH_W'(pix_reg >> shifts_reg[9:5])   & green_max_reg;
        val[LANE_BLUE]  = CH_W'(pix_reg >> shifts_reg[14:10]) & blue_max_reg;
        val[LANE_ALPHA] = CH_W'(pix_reg >> depth_reg)         & alpha_max;
        for (int l = 0; l < NUM_LANES; l++) begin
            dinit_next[l] = div_init(val[l]);
        end
    end

    // last divider step feeds the output register
    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            dlast_next[l] = div_step(dlane_reg[DIV_STAGES-1][l], divisor[l]);
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pvalid_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int k = 0; k < DIV_STAGES; k++) begin
                dvalid_reg[k] <= 1'b0;
            end
        end else begin
            if (en_p) begin
                pvalid_reg <= s_valid;
            end
            if (en_d[0]) begin
                dvalid_reg[0] <= pvalid_reg;
            end
            for (int k = 1; k < DIV_STAGES; k++) begin
                if (en_d[k]) begin
                    dvalid_reg[k] <= dvalid_reg[k-1];
                end
            end
            if (en_out) begin
                m_valid_reg <= dvalid_reg[DIV_STAGES-1];
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (en_p) begin
            pix_reg <= pix_next;
        end
        if (en_d[0]) begin
            for (int l = 0; l < NUM_LANES; l++) begin
                dlane_reg[0][l] <= dinit_next[l];
            end
        end
        for (int k = 1; k < DIV_STAGES; k++) begin
            if (en_d[k]) begin
                for (int l = 0; l < NUM_LANES; l++) begin
                    dlane_reg[k][l] <= div_step(dlane_reg[k-1][l], divisor[l]);
                end
            end
        end
        // a zero maximum gives zero, no alpha bits gives opaque
        if (en_out) begin
            m_red_out_reg   <= (red_max_reg == '0)   ? '0 : dlast_next[LANE_RED].quo;
            m_green_out_reg <= (green_max_reg == '0) ? '0 : dlast_next[LANE_GREEN].quo;
            m_blue_out_reg  <= (blue_max_reg == '0)  ? '0 : dlast_next[LANE_BLUE].quo;
            m_alpha_out_reg <= (alpha_w == '0) ? {CH_W{1'b1}} : dlast_next[LANE_ALPHA].quo;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_red_out   = m_red_out_reg;
    assign m_green_out = m_green_out_reg;
    assign m_blue_out  = m_blue_out_reg;
    assign m_alpha_out = m_alpha_out_reg;

`ifndef NO_ASSERTIONS
    // an accepted item always lands in the first stage
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> pvalid_reg)
        else $error("accepted item not captured in first stage");

    // a blocked first stage keeps its item
    a_first_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        pvalid_reg && !en_d[0] |=> pvalid_reg && $stable(pix_reg))
        else $error("first stage lost its item under stall");

    // a blocked last divider stage keeps its item
    a_last_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        dvalid_reg[DIV_STAGES-1] && !en_out |=> dvalid_reg[DIV_STAGES-1])
        else $error("last divider stage lost its item under stall");

    // an empty output register never blocks the input
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_ready)
        else $error("input stalled with empty output register");
`endif

endmodule
